FILE: hw/rtl/flba_pkg.sv
// Shared types and constants of the free-list block allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package flba_pkg;

  localparam int IDX_W      = 8;
  localparam int OFS_W      = 24;
  localparam int ST_W       = 2;
  localparam int CNT_W      = 9;
  localparam int BYTES_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_READY = 2'd2;
  localparam logic [ST_W-1:0] ST_NULL_REL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_READY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd2;

  typedef struct packed {
    logic sweep_restart;
    logic sweep_we;
    logic launch;
    logic retire;
  } flba_cmd_t;

  typedef struct packed {
    logic setup_req;
    logic sweep_last;
  } flba_stat_t;

endpackage

FILE: hw/rtl/flba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flba_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/flba_datapath.sv
// Allocator datapath: pool registers, free head, link memory, offset multiply, result registers.
// Depends on flba_pkg and flba_ram; driven by commands from flba_ctrl.
module flba_datapath
  import flba_pkg::*;
#(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_func,
  input  logic                  in_has_block,
  input  logic [IDX_W-1:0]      in_block_index,
  input  flba_cmd_t             cmd,
  output flba_stat_t            stat,
  output logic                  out_valid,
  output logic                  out_granted,
  output logic [IDX_W-1:0]      out_got_index,
  output logic [OFS_W-1:0]      out_block_offset,
  output logic [ST_W-1:0]       out_status
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int LW = $clog2(NUM_BLOCKS + 1);
  localparam int CW = (LW > CNT_W) ? LW : CNT_W;
  localparam int PW = IW + BYTES_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_BLOCKS - 1);

  logic               pool_ready_r;
  logic [CNT_W-1:0]   block_count_r;
  logic [BYTES_W-1:0] block_bytes_r;
  logic [LW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      sweep_cnt_r, sweep_cnt_nxt;
  logic               grant_r, grant_nxt;
  logic [ST_W-1:0]    status_r, status_nxt;
  logic [IW-1:0]      blk_r;
  logic               out_valid_r;
  logic               out_granted_r;
  logic [IDX_W-1:0]   out_got_index_r;
  logic [OFS_W-1:0]   out_block_offset_r;
  logic [ST_W-1:0]    out_status_r;

  logic [LW-1:0] n_blocks;
  logic [LW-1:0] succ;
  logic [LW-1:0] chain_link;
  logic [LW-1:0] init_head;
  logic          head_valid;
  logic          rel_in_range;
  logic          rel_we;
  logic [PW-1:0] prod;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [LW-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_ready_r  <= 1'b1;
      block_count_r <= CNT_W'(256);
      block_bytes_r <= BYTES_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_READY:  pool_ready_r  <= cfg_wdata[0];
        CFG_BLOCK_COUNT: block_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_BLOCK_BYTES: block_bytes_r <= cfg_wdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.setup_req  = cfg_we && (cfg_index == CFG_POOL_READY ||
                                      cfg_index == CFG_BLOCK_COUNT ||
                                      cfg_index == CFG_BLOCK_BYTES);
  assign stat.sweep_last = (sweep_cnt_r == LAST_IDX);

  assign n_blocks   = (CW'(block_count_r) > CW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS)
                                                             : LW'(block_count_r);
  assign succ       = LW'(sweep_cnt_r) + LW'(1);
  assign chain_link = (succ < n_blocks) ? succ : NULL_LINK;
  assign init_head  = (n_blocks != '0) ? '0 : NULL_LINK;

  assign head_valid   = (head_r != NULL_LINK);
  assign rel_in_range = (32'(in_block_index) < 32'(NUM_BLOCKS));

  always_comb begin
    grant_nxt  = 1'b0;
    status_nxt = ST_OK;
    rel_we     = 1'b0;
    if (in_func == FUNC_ALLOC) begin
      if (!pool_ready_r) begin
        status_nxt = ST_NOT_READY;
      end else if (!head_valid) begin
        status_nxt = ST_EMPTY;
      end else begin
        grant_nxt = 1'b1;
      end
    end else begin
      if (!in_has_block) begin
        status_nxt = ST_NULL_REL;
      end else if (!pool_ready_r) begin
        status_nxt = ST_NOT_READY;
      end else begin
        rel_we = rel_in_range;
      end
    end
  end

  assign mem_we    = cmd.sweep_we || (cmd.launch && rel_we);
  assign mem_waddr = cmd.sweep_we ? sweep_cnt_r : IW'(in_block_index);
  assign mem_wdata = cmd.sweep_we ? chain_link : head_r;

  flba_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.launch),
    .raddr (head_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    head_nxt = head_r;
    if (cmd.sweep_we) begin
      head_nxt = init_head;
    end else if (cmd.launch && rel_we) begin
      head_nxt = LW'(in_block_index);
    end else if (cmd.retire && grant_r) begin
      head_nxt = mem_rdata;
    end
  end

  always_comb begin
    sweep_cnt_nxt = sweep_cnt_r;
    if (cmd.sweep_restart) begin
      sweep_cnt_nxt = '0;
    end else if (cmd.sweep_we) begin
      sweep_cnt_nxt = sweep_cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_LINK;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      out_valid_r <= cmd.retire;
    end
  end

  assign prod = PW'(blk_r) * PW'(block_bytes_r);

  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      grant_r  <= grant_nxt;
      status_r <= status_nxt;
      blk_r    <= head_r[IW-1:0];
    end
    if (cmd.retire) begin
      out_granted_r      <= grant_r;
      out_got_index_r    <= grant_r ? IDX_W'(blk_r) : '0;
      out_block_offset_r <= grant_r ? OFS_W'(prod) : '0;
      out_status_r       <= status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_got_index    = out_got_index_r;
  assign out_block_offset = out_block_offset_r;
  assign out_status       = out_status_r;

endmodule

FILE: hw/rtl/flba_ctrl.sv
// Allocator controller: sequences the link-memory sweep, item launch and result retire.
// Depends on flba_pkg; commands flba_datapath.
module flba_ctrl
  import flba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  flba_stat_t stat,
  output flba_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd               = '0;
    cmd.sweep_restart = stat.setup_req;
    state_nxt         = state_r;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep_we = !stat.setup_req;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.launch = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.retire = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_SWEEP;
    endcase
    if (stat.setup_req) begin
      state_nxt = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

FILE: hw/rtl/free_list_block_allocator_core.sv
// Free-list block allocator top level: controller plus datapath, assertions at the end.
// Depends on flba_pkg, flba_ctrl, flba_datapath (and flba_ram through the datapath).
// A transfer registers the item; S_EXEC registers its result, strobed on out_valid.
// A new item is taken only after S_EXEC retires the last, as link reads are registered.
// Reset and every pool register write rebuild the link chain, with busy high until the
// sweep has written every link; results cannot be stalled.
module free_list_block_allocator_core
  import flba_pkg::*;
#(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic                  in_has_block,
  input  logic [IDX_W-1:0]      in_block_index,
  output logic                  out_valid,
  output logic                  out_granted,
  output logic [IDX_W-1:0]      out_got_index,
  output logic [OFS_W-1:0]      out_block_offset,
  output logic [ST_W-1:0]       out_status
);

  flba_cmd_t  cmd;
  flba_stat_t stat;

  flba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  flba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_func),
    .in_has_block     (in_has_block),
    .in_block_index   (in_block_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_got_index    (out_got_index),
    .out_block_offset (out_block_offset),
    .out_status       (out_status)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !stat.setup_req) ##1 !stat.setup_req |=> out_valid)
    else $error("transfer without result");

  a_result_had_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !$past(cmd.sweep_we))
    else $error("result without launched item");

  a_refused_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_got_index == '0 && out_block_offset == '0))
    else $error("refused result carries a block");

  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_we |-> busy && !cmd.launch)
    else $error("link sweep while idle");

endmodule

FILE: dv/free_list_block_allocator_core_checker.sv
`timescale 1ns / 100ps
// Response checker for the free-list block allocator: mirrors the link chain from observed
// register writes and request transfers, then compares every strobed response in order.
// Depends on flba_pkg only.
module free_list_block_allocator_core_checker
  import flba_pkg::*;
#(
  parameter int NUM_BLOCKS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_func,
  input  logic                  in_has_block,
  input  logic [IDX_W-1:0]      in_block_index,
  input  logic                  out_valid,
  input  logic                  out_granted,
  input  logic [IDX_W-1:0]      out_got_index,
  input  logic [OFS_W-1:0]      out_block_offset,
  input  logic [ST_W-1:0]       out_status,
  output int                    errors,
  output int                    pending
);

  localparam logic [CNT_W-1:0] NO_BLOCK = CNT_W'(NUM_BLOCKS);

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  got_index;
    logic [OFS_W-1:0]  block_offset;
    logic [ST_W-1:0]   status;
  } grant_t;

  logic [CNT_W-1:0]   chain_link [NUM_BLOCKS];
  logic [CNT_W-1:0]   chain_head;
  logic               pool_up;
  logic [CNT_W-1:0]   pool_blocks;
  logic [BYTES_W-1:0] pool_bytes;
  grant_t             grants_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void chain_pool();
    int n;
    n = (pool_blocks > NUM_BLOCKS) ? NUM_BLOCKS : int'(pool_blocks);
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      chain_link[i] = (i + 1 < n) ? CNT_W'(i + 1) : NO_BLOCK;
    end
    chain_head = (n > 0) ? '0 : NO_BLOCK;
  endfunction

  function automatic grant_t serve_request(logic func, logic has, logic [IDX_W-1:0] idx);
    grant_t      g;
    logic [31:0] product;
    g = '0;
    if (func == FUNC_ALLOC) begin
      if (!pool_up) begin
        g.status = ST_NOT_READY;
      end else if (chain_head >= NUM_BLOCKS) begin
        g.status = ST_EMPTY;
      end else begin
        product        = 32'(chain_head) * 32'(pool_bytes);
        g.granted      = 1'b1;
        g.got_index    = chain_head[IDX_W-1:0];
        g.block_offset = product[OFS_W-1:0];
        g.status       = ST_OK;
        chain_head     = chain_link[chain_head];
      end
    end else if (!has) begin
      g.status = ST_NULL_REL;
    end else if (!pool_up) begin
      g.status = ST_NOT_READY;
    end else begin
      chain_link[idx] = chain_head;
      chain_head      = {1'b0, idx};
      g.status        = ST_OK;
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t seen;
    grant_t want;
    if (!rst_n) begin
      pool_up     = 1'b1;
      pool_blocks = CNT_W'(256);
      pool_bytes  = BYTES_W'(16);
      chain_pool();
      grants_due.delete();
      pending = 0;
    end else begin
      if (out_valid) begin
        seen = {out_granted, out_got_index, out_block_offset, out_status};
        if (grants_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: response with none outstanding: granted=%0b index=%0d offset=%0d status=%0d",
                     $time, seen.granted, seen.got_index, seen.block_offset, seen.status);
          errors++;
        end else begin
          want = grants_due.pop_front();
          if (seen.granted !== want.granted || seen.got_index !== want.got_index ||
              seen.block_offset !== want.block_offset || seen.status !== want.status) begin
            if (errors < 10)
              $display("%0t: response mismatch: expected granted=%0b index=%0d offset=%0d status=%0d,",
                       $time, want.granted, want.got_index, want.block_offset, want.status,
                       " got granted=%0b index=%0d offset=%0d status=%0d",
                       seen.granted, seen.got_index, seen.block_offset, seen.status);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_READY: begin
            pool_up = cfg_wdata[0];
            chain_pool();
          end
          CFG_BLOCK_COUNT: begin
            pool_blocks = cfg_wdata[CNT_W-1:0];
            chain_pool();
          end
          CFG_BLOCK_BYTES: begin
            pool_bytes = cfg_wdata[BYTES_W-1:0];
            chain_pool();
          end
          default: ;
        endcase
      end
      if (start && !busy)
        grants_due.push_back(serve_request(in_func, in_has_block, in_block_index));
      pending = grants_due.size();
    end
  end

endmodule

FILE: dv/free_list_block_allocator_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the free-list block allocator: drives register writes and allocate or
// release requests with random gaps; depends on flba_pkg, the core and the response checker.
module free_list_block_allocator_core_tb;
  import flba_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  logic                  in_func;
  logic                  in_has_block;
  logic [IDX_W-1:0]      in_block_index;
  logic                  out_valid;
  logic                  out_granted;
  logic [IDX_W-1:0]      out_got_index;
  logic [OFS_W-1:0]      out_block_offset;
  logic [ST_W-1:0]       out_status;
  int                    fail_count;
  int                    pending_count;
  int                    idle_pct;
  int                    stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  free_list_block_allocator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_has_block     (in_has_block),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_got_index    (out_got_index),
    .out_block_offset (out_block_offset),
    .out_status       (out_status)
  );

  free_list_block_allocator_core_checker grant_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_has_block     (in_has_block),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_got_index    (out_got_index),
    .out_block_offset (out_block_offset),
    .out_status       (out_status),
    .errors           (fail_count),
    .pending          (pending_count)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic transfer_item(input logic func, input logic has, input logic [IDX_W-1:0] idx);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    start          <= 1'b1;
    in_func        <= func;
    in_has_block   <= has;
    in_block_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0 || busy) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int blocks;
    int span;
    int alloc_pct;
    logic [CFG_DATA_W-1:0] bytes;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_POOL_READY;
    cfg_wdata      = '0;
    start          = 1'b0;
    in_func        = FUNC_ALLOC;
    in_has_block   = 1'b0;
    in_block_index = '0;
    idle_pct       = 26;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // pop from the fresh chain, null release, push and re-pop, double release
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_ALLOC, 1'b1, 8'hFF);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_RELEASE, 1'b0, 8'hFF);
    transfer_item(FUNC_RELEASE, 1'b1, 8'hFF);
    transfer_item(FUNC_ALLOC, 1'b1, 8'hAA);
    transfer_item(FUNC_RELEASE, 1'b1, 8'd1);
    transfer_item(FUNC_RELEASE, 1'b1, 8'd1);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);

    // pool not ready
    write_reg(CFG_POOL_READY, 16'd0);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_RELEASE, 1'b1, 8'd5);
    transfer_item(FUNC_RELEASE, 1'b0, 8'd5);
    write_reg(CFG_POOL_READY, 16'd1);

    // one block of maximum size, release beyond the count
    write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
    write_reg(CFG_BLOCK_COUNT, 16'd1);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_RELEASE, 1'b1, 8'd255);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);

    // empty pool, then a count that saturates
    write_reg(CFG_BLOCK_COUNT, 16'd0);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_RELEASE, 1'b1, 8'd7);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    write_reg(CFG_BLOCK_COUNT, 16'd511);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);
    transfer_item(FUNC_ALLOC, 1'b0, 8'd0);

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 26 : (mode == 1) ? 66 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        case ($urandom_range(3))
          0:       bytes = 16'hFFFF;
          1:       bytes = 16'd1;
          2:       bytes = CFG_DATA_W'($urandom_range(65535));
          default: bytes = CFG_DATA_W'($urandom_range(64, 2));
        endcase
        case ($urandom_range(7))
          0:       blocks = 1;
          1:       blocks = 2;
          2:       blocks = $urandom_range(16, 3);
          3:       blocks = $urandom_range(255, 17);
          4:       blocks = 256;
          5:       blocks = 0;
          6:       blocks = $urandom_range(511, 257);
          default: blocks = $urandom_range(8, 1);
        endcase
        span      = (blocks == 0) ? 1 : (blocks > 256) ? 256 : blocks;
        alloc_pct = $urandom_range(80, 20);
        write_reg(CFG_BLOCK_BYTES, bytes);
        write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(blocks));
        write_reg(CFG_POOL_READY, ($urandom_range(9) != 0) ? 16'd1 : 16'd0);
        for (int n = 0; n < 72; n++) begin
          if (seg == 0 && n == 36)
            drain_results();
          if ($urandom_range(99) < alloc_pct)
            transfer_item(FUNC_ALLOC, 1'($urandom_range(1)), IDX_W'($urandom_range(255)));
          else
            transfer_item(FUNC_RELEASE, $urandom_range(19) != 0,
                          ($urandom_range(3) == 0) ? IDX_W'($urandom_range(255))
                                                   : IDX_W'($urandom_range(span - 1)));
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: free_list_block_allocator_core.f
hw/rtl/flba_pkg.sv
hw/rtl/flba_ram.sv
hw/rtl/flba_datapath.sv
hw/rtl/flba_ctrl.sv
hw/rtl/free_list_block_allocator_core.sv
dv/free_list_block_allocator_core_checker.sv
dv/free_list_block_allocator_core_tb.sv
